### sv/tome_pkg.sv
// Shared types, constants and waveform function for the two-oscillator mixer.
// No dependencies; the mixer core imports this package.
package tome_pkg;

    localparam int SAMPLE_BUDGET = 16001;
    localparam int ADDR_W        = 5;

    // Register map, word index
    localparam logic [2:0] REG_PER_ONE = 3'd0;
    localparam logic [2:0] REG_PER_TWO = 3'd1;
    localparam logic [2:0] REG_MODE    = 3'd2;
    localparam logic [2:0] REG_LEVEL   = 3'd3;
    localparam logic [2:0] REG_ATTACK  = 3'd4;
    localparam logic [2:0] REG_DECAY   = 3'd5;
    localparam logic [2:0] REG_SUSTAIN = 3'd6;
    localparam logic [2:0] REG_RELEASE = 3'd7;

    // Wave codes
    localparam logic [2:0] WAVE_SQUARE  = 3'd0;
    localparam logic [2:0] WAVE_TRI     = 3'd1;
    localparam logic [2:0] WAVE_SAW     = 3'd2;
    localparam logic [2:0] WAVE_ISAW    = 3'd3;
    localparam logic [2:0] WAVE_QUARTER = 3'd4;
    localparam logic [2:0] WAVE_THREEQ  = 3'd5;
    localparam logic [2:0] WAVE_NOISE   = 3'd6;

    localparam int RST_PERIOD_ONE = 40;
    localparam int RST_REPS       = (SAMPLE_BUDGET / RST_PERIOD_ONE) / 2 * 2;
    localparam logic [13:0] RST_BLEN  = 14'((RST_PERIOD_ONE * RST_REPS) % 16384);
    localparam logic [15:0] RST_STEP1 = 16'((65536 / RST_PERIOD_ONE) % 65536);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_WB, S_PHASE, S_MIXSEL, S_ENV, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_REPS, OP_BLEN, OP_STEP1, OP_STEP2, OP_JS1, OP_JS2, OP_A, OP_B,
        OP_MIX, OP_E1, OP_E2, OP_E3, OP_E4
    } t_op;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [15:0] wave_value(input logic [2:0] sel, input logic [10:0] j,
                                               input logic [10:0] t, input logic [15:0] js,
                                               input logic [15:0] noise);
        logic [12:0] t3;
        logic        half, quart, three;
        logic [15:0] w;
        t3    = {2'b0, t} + {1'b0, t, 1'b0};
        half  = j < {1'b0, t[10:1]};
        quart = j < {2'b0, t[10:2]};
        three = j < t3[12:2];
        case (sel)
            WAVE_SQUARE:  w = half ? 16'h7FFF : 16'h8001;
            WAVE_TRI:     w = half ? js - 16'd32767 : 16'd32767 - js;
            WAVE_SAW:     w = js;
            WAVE_ISAW:    w = 16'd32767 - js;
            WAVE_QUARTER: w = quart ? 16'h7FFF : 16'h8001;
            WAVE_THREEQ:  w = three ? 16'h7FFF : 16'h8001;
            WAVE_NOISE:   w = half ? noise : 16'h0000 - noise;
            default:      w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

### sv/tome_if.sv
// Handshake interfaces for the mixer's input and output words.
// No dependencies.
interface tome_in_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic [15:0] random_one;
    logic [15:0] random_two;
    modport source (output valid, restart, random_one, random_two, input ready);
    modport sink   (input valid, restart, random_one, random_two, output ready);
endinterface

interface tome_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               last;
    modport source (output valid, sample_out, last, input ready);
    modport sink   (input valid, sample_out, last, output ready);
endinterface

### sv/two_oscillator_mixer_envelope_core.sv
// Two-oscillator soft mixer with ADSR envelope, one sample per input word.
// Depends on tome_pkg and the interfaces in tome_if.sv.
//
//   port    dir  handshake       payload
//   i_in    in   valid/ready     restart, random_one, random_two
//   o_out   out  valid/ready     sample_out, last
//   apb     in   psel/penable    paddr[4:2] register, pwdata
//
// Every scaling, mix and envelope division runs through one shared 16x16
// multiplier and a 32-step restoring divider; a buffer start adds a multiply
// and two divides, or three when the second period is nonzero. A finished
// word waits while the output register is still full.
// Reset is synchronous, active low. A new input word is taken while a result
// waits in the output register; the next result waits for that slot.
module two_oscillator_mixer_envelope_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tome_in_if.sink                       i_in,
    tome_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tome_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tome_pkg::*;

    // configuration
    logic [9:0]  r_per1;
    logic [10:0] r_per2;
    logic [6:0]  r_mode;
    logic [15:0] r_level;
    logic [11:0] r_att, r_dec, r_sus, r_rel;

    // oscillator and buffer state
    logic [13:0] r_idx, n_idx, r_blen, n_blen;
    logic [9:0]  r_ph1, n_ph1;
    logic [10:0] r_ph2, n_ph2;
    logic [15:0] r_step1, n_step1, r_step2, n_step2;
    logic [15:0] r_nz1, n_nz1, r_nz2, n_nz2;

    // sequencer and shared unit
    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [15:0]        r_rnd1, n_rnd1, r_rnd2, n_rnd2;
    logic [31:0]        r_num, n_num;
    logic [15:0]        r_rem, n_rem, r_den, n_den;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_decay, n_decay;
    logic [15:0]        r_js1, n_js1, r_js2, n_js2;
    logic signed [15:0] r_a, n_a, r_b, n_b, r_d, n_d;
    logic signed [31:0] r_acc, n_acc;
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_osample, n_osample;
    logic               r_olast, n_olast;

    // operand selection
    logic [15:0]        op_x, op_y, op_z;
    logic               op_neg, op_mul_only;

    logic [9:0]         t1e;
    logic [15:0]        w1, w2, rnd1_adj, rnd2_adj;
    logic [7:0]         vol, lvl2;
    logic signed [31:0] res, sum_ab;
    logic [16:0]        div_sh;
    logic               div_ge;
    logic [10:0]        p1;
    logic [11:0]        p2;
    logic [14:0]        idx15, s_ad, s_ads, s_adsr;
    logic [15:0]        i_minus_at, i_minus_ads;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[4:2])
            REG_PER_ONE: prdata = {22'b0, r_per1};
            REG_PER_TWO: prdata = {21'b0, r_per2};
            REG_MODE:    prdata = {25'b0, r_mode};
            REG_LEVEL:   prdata = {16'b0, r_level};
            REG_ATTACK:  prdata = {20'b0, r_att};
            REG_DECAY:   prdata = {20'b0, r_dec};
            REG_SUSTAIN: prdata = {20'b0, r_sus};
            REG_RELEASE: prdata = {20'b0, r_rel};
            default:     prdata = 32'b0;
        endcase
    end

    assign t1e      = (r_per1 == 10'd0) ? 10'd1 : r_per1;
    assign vol      = r_level[7:0];
    assign lvl2     = r_level[15:8];
    assign w1       = wave_value(r_mode[2:0], {1'b0, r_ph1}, {1'b0, t1e}, r_js1, r_nz1);
    assign w2       = wave_value(r_mode[5:3], r_ph2, r_per2, r_js2, r_nz2);
    assign rnd1_adj = r_rnd1 - 16'd32767;
    assign rnd2_adj = r_rnd2 - 16'd32767;
    assign res      = r_neg ? -$signed(r_num) : $signed(r_num);
    assign sum_ab   = 32'(r_a) + 32'(r_b);
    assign div_sh   = {r_rem, r_num[31]};
    assign div_ge   = div_sh >= {1'b0, r_den};
    assign p1       = {1'b0, r_ph1} + 11'd1;
    assign p2       = {1'b0, r_ph2} + 12'd1;
    assign idx15    = {1'b0, r_idx};
    assign s_ad     = {3'b0, r_att} + {3'b0, r_dec};
    assign s_ads    = s_ad + {3'b0, r_sus};
    assign s_adsr   = s_ads + {3'b0, r_rel};
    assign i_minus_at  = {2'b0, r_idx} - {4'b0, r_att};
    assign i_minus_ads = {2'b0, r_idx} - {1'b0, s_ads};

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_osample;
    assign o_out.last       = r_olast;

    // operands of the shared multiply/divide for the current op
    always_comb begin
        op_x        = mag16(r_d);
        op_y        = 16'd255;
        op_z        = {8'b0, vol};
        op_neg      = r_d[15];
        op_mul_only = 1'b0;
        case (r_op)
            OP_REPS: begin
                op_x   = 16'(SAMPLE_BUDGET);
                op_y   = 16'd1;
                op_z   = {6'b0, t1e};
                op_neg = 1'b0;
            end
            OP_BLEN: begin
                op_x        = {6'b0, t1e};
                op_y        = r_acc[15:0];
                op_neg      = 1'b0;
                op_mul_only = 1'b1;
            end
            OP_STEP1: begin
                // 2^16 as 256 * 256
                op_x   = 16'd256;
                op_y   = 16'd256;
                op_z   = {6'b0, t1e};
                op_neg = 1'b0;
            end
            OP_STEP2: begin
                op_x   = 16'd256;
                op_y   = 16'd256;
                op_z   = {5'b0, r_per2};
                op_neg = 1'b0;
            end
            OP_JS1: begin
                op_x        = {6'b0, r_ph1};
                op_y        = r_step1;
                op_neg      = 1'b0;
                op_mul_only = 1'b1;
            end
            OP_JS2: begin
                op_x        = {5'b0, r_ph2};
                op_y        = r_step2;
                op_neg      = 1'b0;
                op_mul_only = 1'b1;
            end
            OP_A: begin
                op_x   = mag16(w1);
                op_y   = {8'b0, vol};
                op_z   = 16'd255;
                op_neg = w1[15];
            end
            OP_B: begin
                op_x   = mag16(w2);
                op_y   = {8'b0, lvl2};
                op_z   = 16'd255;
                op_neg = w2[15];
            end
            OP_MIX: begin
                // both negative: add ab/32768, both positive: subtract ab/32767
                op_x   = mag16(r_a);
                op_y   = mag16(r_b);
                op_z   = r_a[15] ? 16'd32768 : 16'd32767;
                op_neg = ~r_a[15];
            end
            OP_E1: begin
                op_y = {2'b0, r_idx};
                op_z = {4'b0, r_att};
            end
            OP_E2: begin
                op_y = 16'd255;
                op_z = {8'b0, vol};
            end
            OP_E3: begin
                op_y = i_minus_at;
                op_z = {4'b0, r_dec};
            end
            OP_E4: begin
                op_y = i_minus_ads;
                op_z = {4'b0, r_rel};
            end
            default: begin
                op_x = mag16(r_d);
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_blen    = r_blen;
        n_ph1     = r_ph1;
        n_ph2     = r_ph2;
        n_step1   = r_step1;
        n_step2   = r_step2;
        n_nz1     = r_nz1;
        n_nz2     = r_nz2;
        n_rnd1    = r_rnd1;
        n_rnd2    = r_rnd2;
        n_num     = r_num;
        n_rem     = r_rem;
        n_den     = r_den;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_decay   = r_decay;
        n_js1     = r_js1;
        n_js2     = r_js2;
        n_a       = r_a;
        n_b       = r_b;
        n_d       = r_d;
        n_acc     = r_acc;
        n_ovalid  = r_ovalid;
        n_osample = r_osample;
        n_olast   = r_olast;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rnd1 = i_in.random_one;
                    n_rnd2 = i_in.random_two;
                    if (i_in.restart || r_idx >= r_blen) begin
                        n_op    = OP_REPS;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_PHASE;
                    end
                end
            end
            S_MUL: begin
                n_num   = 32'(op_x) * 32'(op_y);
                n_den   = op_z;
                n_neg   = op_neg;
                n_rem   = 16'd0;
                n_cnt   = 5'd0;
                n_state = op_mul_only ? S_WB : S_DIV;
            end
            S_DIV: begin
                n_rem = div_ge ? 16'(div_sh - {1'b0, r_den}) : div_sh[15:0];
                n_num = {r_num[30:0], div_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = S_MUL;
                case (r_op)
                    OP_REPS: begin
                        n_acc = {res[31:1], 1'b0};
                        n_op  = OP_BLEN;
                    end
                    OP_BLEN: begin
                        n_blen = r_num[13:0];
                        n_op   = OP_STEP1;
                    end
                    OP_STEP1, OP_STEP2: begin
                        if (r_op == OP_STEP1) begin
                            n_step1 = r_num[15:0];
                            n_step2 = 16'd0;
                        end else begin
                            n_step2 = r_num[15:0];
                        end
                        if (r_op == OP_STEP1 && r_per2 != 11'd0) begin
                            n_op = OP_STEP2;
                        end else begin
                            // start the buffer
                            n_idx   = 14'd1;
                            n_ph1   = 10'd0;
                            n_ph2   = 11'd0;
                            n_nz1   = rnd1_adj;
                            n_nz2   = rnd2_adj;
                            n_state = S_PHASE;
                        end
                    end
                    OP_JS1: begin
                        n_js1 = r_num[15:0];
                        n_op  = OP_JS2;
                    end
                    OP_JS2: begin
                        n_js2 = r_num[15:0];
                        n_op  = OP_A;
                    end
                    OP_A: begin
                        n_a = res[15:0];
                        if (r_per2 != 11'd0) begin
                            n_op = OP_B;
                        end else begin
                            n_b     = 16'sd0;
                            n_state = S_MIXSEL;
                        end
                    end
                    OP_B: begin
                        n_b     = res[15:0];
                        n_state = S_MIXSEL;
                    end
                    OP_MIX: begin
                        n_d     = 16'(sum_ab + res);
                        n_state = S_ENV;
                    end
                    OP_E1: begin
                        n_d     = res[15:0];
                        n_decay = 1'b0;
                        n_op    = OP_E2;
                    end
                    OP_E2: begin
                        if (r_decay) begin
                            n_acc = res;
                            n_op  = OP_E3;
                        end else begin
                            n_d     = res[15:0];
                            n_state = S_OUT;
                        end
                    end
                    OP_E3: begin
                        n_d     = 16'(r_acc - res);
                        n_state = S_OUT;
                    end
                    OP_E4: begin
                        n_d     = 16'(32'(r_d) - res);
                        n_state = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_PHASE: begin
                if (p1 >= {1'b0, t1e}) begin
                    n_ph1 = 10'd0;
                    n_nz1 = rnd1_adj;
                end else begin
                    n_ph1 = p1[9:0];
                end
                if (r_per2 == 11'd0) begin
                    n_ph2 = 11'd0;
                end else if (p2 >= {1'b0, r_per2}) begin
                    n_ph2 = 11'd0;
                    n_nz2 = rnd2_adj;
                end else begin
                    n_ph2 = p2[10:0];
                end
                n_op    = OP_JS1;
                n_state = S_MUL;
            end
            S_MIXSEL: begin
                if ((r_a[15] && r_b[15]) ||
                    (!r_a[15] && r_a != 16'sd0 && !r_b[15] && r_b != 16'sd0)) begin
                    n_op    = OP_MIX;
                    n_state = S_MUL;
                end else begin
                    n_d     = sum_ab[15:0];
                    n_state = S_ENV;
                end
            end
            S_ENV: begin
                n_state = S_OUT;
                if (r_mode[6]) begin
                    if (r_idx <= {2'b0, r_att}) begin
                        if (vol == 8'd0) begin
                            n_d = 16'sd0;
                        end else begin
                            n_op    = OP_E1;
                            n_state = S_MUL;
                        end
                    end else if (idx15 < s_ad) begin
                        if (vol == 8'd0) begin
                            n_d = 16'sd0;
                        end else begin
                            n_decay = 1'b1;
                            n_op    = OP_E2;
                            n_state = S_MUL;
                        end
                    end else if (idx15 > s_ads) begin
                        if (idx15 > s_adsr) begin
                            n_d = 16'sd0;
                        end else begin
                            n_op    = OP_E4;
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_OUT: begin
                // hold until the output slot frees up
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_osample = r_d;
                    n_olast   = (idx15 + 15'd1) >= {1'b0, r_blen};
                    n_idx     = r_idx + 14'd1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_REPS;
            r_ovalid <= 1'b0;
            r_per1   <= 10'(RST_PERIOD_ONE);
            r_per2   <= 11'd0;
            r_mode   <= 7'd56;
            r_level  <= 16'd128;
            r_att    <= 12'd1000;
            r_dec    <= 12'd1000;
            r_sus    <= 12'd4000;
            r_rel    <= 12'd1000;
            r_idx    <= 14'd1;
            r_blen   <= RST_BLEN;
            r_ph1    <= 10'd0;
            r_ph2    <= 11'd0;
            r_step1  <= RST_STEP1;
            r_step2  <= 16'd0;
            r_nz1    <= 16'd0;
            r_nz2    <= 16'd0;
            r_decay  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
            r_blen   <= n_blen;
            r_ph1    <= n_ph1;
            r_ph2    <= n_ph2;
            r_step1  <= n_step1;
            r_step2  <= n_step2;
            r_nz1    <= n_nz1;
            r_nz2    <= n_nz2;
            r_decay  <= n_decay;
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_PER_ONE: r_per1  <= pwdata[9:0];
                    REG_PER_TWO: r_per2  <= pwdata[10:0];
                    REG_MODE:    r_mode  <= pwdata[6:0];
                    REG_LEVEL:   r_level <= pwdata[15:0];
                    REG_ATTACK:  r_att   <= pwdata[11:0];
                    REG_DECAY:   r_dec   <= pwdata[11:0];
                    REG_SUSTAIN: r_sus   <= pwdata[11:0];
                    REG_RELEASE: r_rel   <= pwdata[11:0];
                    default:     r_rel   <= r_rel;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rnd1    <= n_rnd1;
        r_rnd2    <= n_rnd2;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_js1     <= n_js1;
        r_js2     <= n_js2;
        r_a       <= n_a;
        r_b       <= n_b;
        r_d       <= n_d;
        r_acc     <= n_acc;
        r_osample <= n_osample;
        r_olast   <= n_olast;
    end

endmodule
